// File: rtl/ldfd_pkg.sv
// Shared constants, types and the CRC-8 step for the range-sensor frame deframer.
package ldfd_pkg;

  // Sync pair and CRC polynomial
  localparam logic [7:0] SYNC_FIRST  = 8'h54;
  localparam logic [7:0] SYNC_SECOND = 8'h2C;
  localparam logic [7:0] CRC_POLY    = 8'h4D;

  // Point store entry: distance in the upper bits, intensity in the lower
  localparam int unsigned PT_W = 24;

  // Status codes carried on each result
  localparam logic STATUS_POINT = 1'b0;
  localparam logic STATUS_BAD   = 1'b1;

  // Per-frame fields handed from the parser to the result stage
  typedef struct packed {
    logic        bad;
    logic [15:0] speed;
    logic [15:0] angle_start;
    logic [15:0] angle_end;
    logic [15:0] stamp;
    logic [7:0]  crc_rx;
    logic [7:0]  crc_calc;
  } desc_t;

  // One CRC-8 update, MSB first, no reflection
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // Running CRC once both sync bytes are in
  localparam logic [7:0] SYNC_CRC = crc8_step(crc8_step(8'h00, SYNC_FIRST), SYNC_SECOND);

endpackage

// File: rtl/ldfd_front.sv
// Byte parser: sync hunt, running CRC, field capture and point writes.
module ldfd_front import ldfd_pkg::*; #(
  parameter int unsigned POINTS_PER_FRAME = 12,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       rx_byte_i,
  // point store write
  output logic             pt_we_o,
  output logic [IDX_W-1:0] pt_idx_o,
  output logic [PT_W-1:0]  pt_data_o,
  // frame descriptor push
  output logic             push_o,
  output desc_t            desc_o
);

  localparam int unsigned FRAME_LEN = 11 + 3 * POINTS_PER_FRAME;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);

  localparam logic [POS_W-1:0] POS_SPEED_LO = POS_W'(2);
  localparam logic [POS_W-1:0] POS_SPEED_HI = POS_W'(3);
  localparam logic [POS_W-1:0] POS_A0_LO    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_A0_HI    = POS_W'(5);
  localparam logic [POS_W-1:0] POS_A1_LO    = POS_W'(6 + 3 * POINTS_PER_FRAME);
  localparam logic [POS_W-1:0] POS_A1_HI    = POS_W'(7 + 3 * POINTS_PER_FRAME);
  localparam logic [POS_W-1:0] POS_TS_LO    = POS_W'(8 + 3 * POINTS_PER_FRAME);
  localparam logic [POS_W-1:0] POS_TS_HI    = POS_W'(9 + 3 * POINTS_PER_FRAME);
  localparam logic [POS_W-1:0] POS_CRC      = POS_W'(FRAME_LEN - 1);

  // Phase within a point: distance low, distance high, intensity
  localparam logic [1:0] PH_DLO = 2'd0;
  localparam logic [1:0] PH_DHI = 2'd1;
  localparam logic [1:0] PH_INT = 2'd2;

  typedef enum logic [1:0] {
    ST_HUNT = 2'b01,
    ST_BODY = 2'b10
  } front_state_e;

  front_state_e     state_q, state_d;
  logic             hdr_q, hdr_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       crc_q, crc_d;
  logic [1:0]       ph_q, ph_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic [7:0]       lo_q;
  logic [15:0]      dist_q, speed_q, a0_q, a1_q, ts_q;

  // Control path
  always_comb begin
    state_d = state_q;
    hdr_d   = hdr_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    ph_d    = ph_q;
    pidx_d  = pidx_q;
    pt_we_o = 1'b0;
    push_o  = 1'b0;
    if (fire_i) begin
      unique case (state_q)
        ST_HUNT: begin
          if (hdr_q && (rx_byte_i == SYNC_SECOND)) begin
            state_d = ST_BODY;
            pos_d   = POS_SPEED_LO;
            crc_d   = SYNC_CRC;
            hdr_d   = 1'b0;
            ph_d    = PH_DLO;
            pidx_d  = '0;
          end else begin
            hdr_d = (rx_byte_i == SYNC_FIRST);
          end
        end
        ST_BODY: begin
          if (pos_q == POS_CRC) begin
            push_o  = 1'b1;
            state_d = ST_HUNT;
            pos_d   = '0;
            hdr_d   = 1'b0;
            crc_d   = '0;
          end else begin
            crc_d = crc8_step(crc_q, rx_byte_i);
            pos_d = pos_q + POS_W'(1);
            if ((pos_q != POS_SPEED_LO) && (pos_q != POS_SPEED_HI) &&
                (pos_q != POS_A0_LO) && (pos_q != POS_A0_HI) &&
                (pos_q != POS_A1_LO) && (pos_q != POS_A1_HI) &&
                (pos_q != POS_TS_LO) && (pos_q != POS_TS_HI)) begin
              // point region
              if (ph_q == PH_INT) begin
                pt_we_o = 1'b1;
                ph_d    = PH_DLO;
                pidx_d  = pidx_q + IDX_W'(1);
              end else begin
                ph_d = ph_q + 2'd1;
              end
            end
          end
        end
        default: begin
          state_d = ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      hdr_q   <= 1'b0;
      pos_q   <= '0;
      crc_q   <= '0;
      ph_q    <= PH_DLO;
      pidx_q  <= '0;
    end else begin
      state_q <= state_d;
      hdr_q   <= hdr_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      ph_q    <= ph_d;
      pidx_q  <= pidx_d;
    end
  end

  // Field capture: low byte always latched, words completed on the high byte
  always_ff @(posedge clk_i) begin
    if (fire_i && (state_q == ST_BODY)) begin
      lo_q <= rx_byte_i;
      if (pos_q == POS_SPEED_HI) speed_q <= {rx_byte_i, lo_q};
      if (pos_q == POS_A0_HI)    a0_q    <= {rx_byte_i, lo_q};
      if (pos_q == POS_A1_HI)    a1_q    <= {rx_byte_i, lo_q};
      if (pos_q == POS_TS_HI)    ts_q    <= {rx_byte_i, lo_q};
      if (ph_q == PH_DHI)        dist_q  <= {rx_byte_i, lo_q};
    end
  end

  assign pt_idx_o  = pidx_q;
  assign pt_data_o = {dist_q, rx_byte_i};

  // Descriptor on the CRC byte
  always_comb begin
    desc_o.bad         = (rx_byte_i != crc_q);
    desc_o.speed       = speed_q;
    desc_o.angle_start = a0_q;
    desc_o.angle_end   = a1_q;
    desc_o.stamp       = ts_q;
    desc_o.crc_rx      = rx_byte_i;
    desc_o.crc_calc    = crc_q;
  end

endmodule

// File: rtl/ldfd_buffer.sv
// Two-slot frame queue: descriptors plus a banked point store, one bank per slot.
module ldfd_buffer import ldfd_pkg::*; #(
  parameter int unsigned POINTS_PER_FRAME = 12,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // parser side
  input  logic             pt_we_i,
  input  logic [IDX_W-1:0] pt_widx_i,
  input  logic [PT_W-1:0]  pt_wdata_i,
  input  logic             push_i,
  input  desc_t            desc_i,
  output logic             full_o,
  // result side
  output logic             empty_o,
  output desc_t            head_o,
  input  logic             pop_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [PT_W-1:0]  rd_data_o
);

  localparam int unsigned DEPTH = 2 * POINTS_PER_FRAME;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [PT_W-1:0] mem_q [DEPTH];
  desc_t           desc_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic [AW-1:0]   waddr, raddr;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = desc_q[rd_ptr_q];

  // Bank select: slot one sits above the first frame's points
  assign waddr = wr_ptr_q ? AW'(POINTS_PER_FRAME) + AW'(pt_widx_i) : AW'(pt_widx_i);
  assign raddr = rd_ptr_q ? AW'(POINTS_PER_FRAME) + AW'(rd_idx_i) : AW'(rd_idx_i);

  // Point store, registered read
  always_ff @(posedge clk_i) begin
    if (pt_we_i) begin
      mem_q[waddr] <= pt_wdata_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      desc_q[wr_ptr_q] <= desc_i;
    end
  end

  // Slot pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// File: rtl/ldfd_back.sv
// Result sequencer: walks the head frame's points through a read stage and an output register.
module ldfd_back import ldfd_pkg::*; #(
  parameter int unsigned POINTS_PER_FRAME = 12,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // queue side
  input  logic             empty_i,
  input  desc_t            head_i,
  output logic             pop_o,
  output logic             rd_en_o,
  output logic [IDX_W-1:0] rd_idx_o,
  input  logic [PT_W-1:0]  rd_data_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             status_o,
  output logic [3:0]       point_index_o,
  output logic [15:0]      distance_o,
  output logic [7:0]       intensity_o,
  output logic [15:0]      rotation_speed_o,
  output logic [15:0]      first_angle_o,
  output logic [15:0]      final_angle_o,
  output logic [15:0]      stamp_o,
  output logic [7:0]       crc_received_o,
  output logic [7:0]       crc_computed_o,
  output logic             last_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_FRAME - 1);

  logic             s1_valid_q, s2_valid_q;
  desc_t            s1_desc_q;
  logic [3:0]       s1_idx_q;
  logic             s1_last_q;
  logic [IDX_W-1:0] pt_q;
  logic             s2_adv, issue, issue_last;

  // Stage movement
  assign s2_adv     = !s2_valid_q || out_ready_i;
  assign issue      = !empty_i && (!s1_valid_q || s2_adv);
  assign issue_last = head_i.bad || (pt_q == LAST_IDX);
  assign pop_o      = issue && issue_last;
  assign rd_en_o    = issue;
  assign rd_idx_o   = pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      pt_q       <= '0;
    end else begin
      if (issue) begin
        s1_valid_q <= 1'b1;
        pt_q       <= issue_last ? '0 : pt_q + IDX_W'(1);
      end else if (s2_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_desc_q <= head_i;
      s1_idx_q  <= head_i.bad ? 4'd0 : 4'(pt_q);
      s1_last_q <= issue_last;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      status_o         <= s1_desc_q.bad ? STATUS_BAD : STATUS_POINT;
      point_index_o    <= s1_idx_q;
      distance_o       <= s1_desc_q.bad ? 16'd0 : rd_data_i[PT_W-1:8];
      intensity_o      <= s1_desc_q.bad ? 8'd0 : rd_data_i[7:0];
      rotation_speed_o <= s1_desc_q.speed;
      first_angle_o    <= s1_desc_q.angle_start;
      final_angle_o    <= s1_desc_q.angle_end;
      stamp_o          <= s1_desc_q.stamp;
      crc_received_o   <= s1_desc_q.crc_rx;
      crc_computed_o   <= s1_desc_q.crc_calc;
      last_o           <= s1_last_q;
    end
  end

  assign out_valid_o = s2_valid_q;

endmodule

// File: rtl/lidar_frame_deframer_crc8_core.sv
// Top level of the range-sensor frame deframer with CRC-8 check.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   input   | in        | in_valid_i / in_ready_o | rx_byte_i
//   result  | out       | out_valid_o/out_ready_i | status_o .. last_o (11 fields)
//
// One byte is taken per cycle while a frame slot is free; the parser works one byte a cycle
// through its position counter and CRC register. A good frame yields POINTS_PER_FRAME results,
// one per cycle while the receiver is ready, from the point store; a bad frame yields one.
// A request is refused only while both frame slots hold undrained frames.
// After the CRC byte, the frame is queued, then read through the read stage and output register.
// Reset empties the queue and restarts the sync hunt; no clearing pass.
module lidar_frame_deframer_crc8_core import ldfd_pkg::*; #(
  parameter int unsigned POINTS_PER_FRAME = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [3:0]  point_index_o,
  output logic [15:0] distance_o,
  output logic [7:0]  intensity_o,
  output logic [15:0] rotation_speed_o,
  output logic [15:0] first_angle_o,
  output logic [15:0] final_angle_o,
  output logic [15:0] stamp_o,
  output logic [7:0]  crc_received_o,
  output logic [7:0]  crc_computed_o,
  output logic        last_o
);

  localparam int unsigned IDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;

  logic             fire, full, empty, push, pop, pt_we, rd_en;
  logic [IDX_W-1:0] pt_widx, rd_idx;
  logic [PT_W-1:0]  pt_wdata, rd_data;
  desc_t            desc, head;

  assign in_ready_o = !full;
  assign fire       = in_valid_i && in_ready_o;

  ldfd_front #(
    .POINTS_PER_FRAME(POINTS_PER_FRAME),
    .IDX_W           (IDX_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .rx_byte_i(rx_byte_i),
    .pt_we_o  (pt_we),
    .pt_idx_o (pt_widx),
    .pt_data_o(pt_wdata),
    .push_o   (push),
    .desc_o   (desc)
  );

  ldfd_buffer #(
    .POINTS_PER_FRAME(POINTS_PER_FRAME),
    .IDX_W           (IDX_W)
  ) u_buffer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pt_we_i   (pt_we),
    .pt_widx_i (pt_widx),
    .pt_wdata_i(pt_wdata),
    .push_i    (push),
    .desc_i    (desc),
    .full_o    (full),
    .empty_o   (empty),
    .head_o    (head),
    .pop_i     (pop),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  ldfd_back #(
    .POINTS_PER_FRAME(POINTS_PER_FRAME),
    .IDX_W           (IDX_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .rd_en_o         (rd_en),
    .rd_idx_o        (rd_idx),
    .rd_data_i       (rd_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .point_index_o   (point_index_o),
    .distance_o      (distance_o),
    .intensity_o     (intensity_o),
    .rotation_speed_o(rotation_speed_o),
    .first_angle_o   (first_angle_o),
    .final_angle_o   (final_angle_o),
    .stamp_o         (stamp_o),
    .crc_received_o  (crc_received_o),
    .crc_computed_o  (crc_computed_o),
    .last_o          (last_o)
  );

endmodule

// File: rtl/ldfd_checker.sv
// Port-level checks for the deframer top level, with its bind.
module ldfd_checker #(
  parameter int unsigned POINTS_PER_FRAME = 12
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        status_o,
  input logic [3:0]  point_index_o,
  input logic [15:0] distance_o,
  input logic [7:0]  intensity_o,
  input logic [15:0] rotation_speed_o,
  input logic [15:0] first_angle_o,
  input logic [15:0] final_angle_o,
  input logic [15:0] stamp_o,
  input logic [7:0]  crc_received_o,
  input logic [7:0]  crc_computed_o,
  input logic        last_o
);

  localparam logic [3:0] LAST_IDX = 4'(POINTS_PER_FRAME - 1);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(point_index_o) &&
      $stable(distance_o) && $stable(last_o) && $stable(status_o))
    else $error("result changed while stalled");

  // A rejected frame gives one empty result that closes the frame
  a_bad_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o && point_index_o == 4'd0 &&
      distance_o == 16'd0 && intensity_o == 8'd0)
    else $error("malformed error result");

  // Status agrees with the two CRC fields
  a_crc_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == (crc_received_o != crc_computed_o)))
    else $error("status disagrees with CRC fields");

  // A good frame closes on its final point
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> (last_o == (point_index_o == LAST_IDX)))
    else $error("last flag on wrong point");

endmodule

bind lidar_frame_deframer_crc8_core ldfd_checker #(
  .POINTS_PER_FRAME(POINTS_PER_FRAME)
) u_ldfd_checker (.*);

// File: tb/sv/lidar_frame_deframer_crc8_core_tb.sv
// Self-checking testbench for the range-sensor frame deframer with CRC-8 check.
module lidar_frame_deframer_crc8_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ldfd_pkg::*;

  localparam int unsigned NUM_POINTS  = 12;
  localparam int unsigned FRAME_LEN   = 11 + 3 * NUM_POINTS;
  localparam int unsigned STORE_LEN   = FRAME_LEN - 3;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_MAX  = 10;

  // Payload patterns for generated frames
  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_EXTREME
  } fill_e;

  // One result as the block presents it
  typedef struct packed {
    logic        status;
    logic [3:0]  idx;
    logic [15:0] dist_raw;
    logic [7:0]  inten;
    logic [15:0] speed;
    logic [15:0] angle_a;
    logic [15:0] angle_b;
    logic [15:0] stamp;
    logic [7:0]  crc_rx;
    logic [7:0]  crc_calc;
    logic        last;
  } point_rec_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        status_o;
  logic [3:0]  point_index_o;
  logic [15:0] distance_o;
  logic [7:0]  intensity_o;
  logic [15:0] rotation_speed_o;
  logic [15:0] first_angle_o;
  logic [15:0] final_angle_o;
  logic [15:0] stamp_o;
  logic [7:0]  crc_received_o;
  logic [7:0]  crc_computed_o;
  logic        last_o;

  // Byte stream waiting to be offered, and results still owed by the block
  logic [7:0]  rx_stream_q[$];
  point_rec_t  frame_results_q[$];

  // Predictor state
  int unsigned frame_pos;
  logic        sync_half;
  logic [7:0]  crc_acc;
  logic [7:0]  frame_store[STORE_LEN];

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          rx_hold_left   = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;

  lidar_frame_deframer_crc8_core #(
    .POINTS_PER_FRAME(NUM_POINTS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .point_index_o   (point_index_o),
    .distance_o      (distance_o),
    .intensity_o     (intensity_o),
    .rotation_speed_o(rotation_speed_o),
    .first_angle_o   (first_angle_o),
    .final_angle_o   (final_angle_o),
    .stamp_o         (stamp_o),
    .crc_received_o  (crc_received_o),
    .crc_computed_o  (crc_computed_o),
    .last_o          (last_o)
  );

  // 100 MHz clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // CRC-8, one bit at a time, MSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ din[k];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // Little-endian word at a frame offset (offset 2 upwards)
  function automatic logic [15:0] frame_word(input int unsigned off);
    return {frame_store[off - 1], frame_store[off - 2]};
  endfunction

  // Advance the deframer by one accepted byte, owing results on the CRC byte
  function automatic void deframe_byte(input logic [7:0] b);
    point_rec_t r;
    int unsigned off;
    if (frame_pos == 0) begin
      if (sync_half && b == SYNC_SECOND) begin
        crc_acc   = crc8_next(crc8_next(8'h00, SYNC_FIRST), b);
        frame_pos = 2;
        sync_half = 1'b0;
      end else begin
        sync_half = (b == SYNC_FIRST);
      end
    end else if (frame_pos < FRAME_LEN - 1) begin
      frame_store[frame_pos - 2] = b;
      crc_acc   = crc8_next(crc_acc, b);
      frame_pos = frame_pos + 1;
    end else begin
      r.speed    = frame_word(2);
      r.angle_a  = frame_word(4);
      r.angle_b  = frame_word(6 + 3 * NUM_POINTS);
      r.stamp    = frame_word(8 + 3 * NUM_POINTS);
      r.crc_rx   = b;
      r.crc_calc = crc_acc;
      if (b != crc_acc) begin
        // rejected frame: one error result, point fields zero
        r.status   = STATUS_BAD;
        r.idx      = '0;
        r.dist_raw = '0;
        r.inten    = '0;
        r.last     = 1'b1;
        frame_results_q.push_back(r);
      end else begin
        for (int i = 0; i < NUM_POINTS; i++) begin
          off        = 6 + 3 * i;
          r.status   = STATUS_POINT;
          r.idx      = i[3:0];
          r.dist_raw = frame_word(off);
          r.inten    = frame_store[off];
          r.last     = (i == NUM_POINTS - 1);
          frame_results_q.push_back(r);
        end
      end
      frame_pos = 0;
      sync_half = 1'b0;
      crc_acc   = 8'h00;
    end
  endfunction

  // Field compare; only the first few mismatches are printed
  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
    end
  endtask

  // Sender: offer queued bytes, predict on each accepted request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
    end else begin
      if (in_valid_i && in_ready_o) begin
        deframe_byte(rx_byte_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (rx_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_stream_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result against the oldest owed one
  always @(posedge clk_i) begin : result_monitor
    point_rec_t got;
    point_rec_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{status_o, point_index_o, distance_o, intensity_o, rotation_speed_o,
                first_angle_o, final_angle_o, stamp_o, crc_received_o, crc_computed_o,
                last_o};
        if (frame_results_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("unexpected result: %p", got);
          end
        end else begin
          want = frame_results_q.pop_front();
          cmp_field("status",         want.status,   got.status);
          cmp_field("point_index",    want.idx,      got.idx);
          cmp_field("distance",       want.dist_raw, got.dist_raw);
          cmp_field("intensity",      want.inten,    got.inten);
          cmp_field("rotation_speed", want.speed,    got.speed);
          cmp_field("first_angle",    want.angle_a,  got.angle_a);
          cmp_field("final_angle",    want.angle_b,  got.angle_b);
          cmp_field("stamp",          want.stamp,    got.stamp);
          cmp_field("crc_received",   want.crc_rx,   got.crc_rx);
          cmp_field("crc_computed",   want.crc_calc, got.crc_calc);
          cmp_field("last",           want.last,     got.last);
        end
      end
      out_ready_i <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Whole frame with good or spoilt CRC; last_byte >= 0 forces the CRC byte
  task automatic queue_frame(input fill_e fill, input bit spoil, input int last_byte = -1);
    logic [7:0] fb[FRAME_LEN];
    logic [7:0] crc;
    fb[0] = SYNC_FIRST;
    fb[1] = SYNC_SECOND;
    for (int k = 2; k < FRAME_LEN - 1; k++) begin
      case (fill)
        FILL_ZERO:    fb[k] = 8'h00;
        FILL_ONES:    fb[k] = 8'hFF;
        FILL_EXTREME: fb[k] = $urandom_range(1) ? 8'hFF : 8'h00;
        default:      fb[k] = 8'($urandom_range(255));
      endcase
    end
    crc = 8'h00;
    for (int k = 0; k < FRAME_LEN - 1; k++) begin
      crc = crc8_next(crc, fb[k]);
    end
    fb[FRAME_LEN - 1] = spoil ? crc ^ 8'($urandom_range(1, 255)) : crc;
    if (last_byte >= 0) begin
      fb[FRAME_LEN - 1] = last_byte[7:0];
    end
    for (int k = 0; k < FRAME_LEN; k++) begin
      rx_stream_q.push_back(fb[k]);
    end
  endtask

  // Line noise between frames, biased towards sync bytes
  function automatic int queue_noise(input int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        rx_stream_q.push_back(SYNC_FIRST);
      end else if (pick < 40) begin
        rx_stream_q.push_back(SYNC_SECOND);
      end else begin
        rx_stream_q.push_back(8'($urandom_range(255)));
      end
    end
    return n;
  endfunction

  // Mostly well-formed frames, some spoilt, some cut short, noise between
  task automatic queue_random_traffic(input int n_bytes);
    int queued;
    int pick;
    int cut;
    queued = 0;
    while (queued < n_bytes) begin
      queued += queue_noise($urandom_range(3));
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_frame(($urandom_range(9) == 0) ? FILL_EXTREME : FILL_RANDOM, 1'b0);
        queued += FRAME_LEN;
      end else if (pick < 88) begin
        queue_frame(FILL_RANDOM, 1'b1);
        queued += FRAME_LEN;
      end else begin
        // truncated frame: following bytes are taken as its payload
        rx_stream_q.push_back(SYNC_FIRST);
        rx_stream_q.push_back(SYNC_SECOND);
        cut = $urandom_range(2, 20);
        queued += 2 + queue_noise(cut);
      end
    end
  endtask

  // Wait until every queued byte is sent and every owed result has come back
  task automatic wait_drained();
    while (rx_stream_q.size() != 0 || in_valid_i || frame_results_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    frame_pos = 0;
    sync_half = 1'b0;
    crc_acc   = 8'h00;
    foreach (frame_store[k]) frame_store[k] = 8'h00;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: lone second sync, broken header, then a doubled first sync
    rx_stream_q.push_back(SYNC_SECOND);
    rx_stream_q.push_back(8'h00);
    rx_stream_q.push_back(8'hFF);
    rx_stream_q.push_back(SYNC_FIRST);
    rx_stream_q.push_back(8'h11);
    rx_stream_q.push_back(SYNC_FIRST);
    queue_frame(FILL_ONES, 1'b0);
    queue_frame(FILL_ZERO, 1'b0);
    // CRC byte that looks like a first sync must not pair with a following 0x2C
    queue_frame(FILL_RANDOM, 1'b1, SYNC_FIRST);
    rx_stream_q.push_back(SYNC_SECOND);
    wait_drained();

    // Receiver holds off while frames keep coming, so the input backs up
    rx_hold_left = 600;
    for (int k = 0; k < 3; k++) begin
      queue_frame(FILL_RANDOM, 1'b0);
    end
    wait_drained();

    // Random traffic under each idling pattern
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random_traffic(30);
    wait_drained();

    send_idle_pct  = 82;
    recv_stall_pct = 0;
    queue_random_traffic(30);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 82;
    queue_random_traffic(30);
    wait_drained();

    send_idle_pct  = 7;
    recv_stall_pct = 7;
    queue_random_traffic(30);
    wait_drained();

    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (frame_results_q.size() != 0) begin
      $display("%0d results never arrived", frame_results_q.size());
      mismatch_count += frame_results_q.size();
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
